// ===== sv/sobel_et_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_et_pkg
// Shared types and constants of the Sobel edge threshold unit.
// ----------------------------------------------------------------------------
package sobel_et_pkg;

    // field widths
    localparam int PIX_W  = 8;   // luminance sample
    localparam int THR_W  = 11;  // edge threshold register
    localparam int FWID_W = 11;  // frame width register
    localparam int HGT_W  = 13;  // frame height register
    localparam int ROW_W  = 14;  // row counter, holds height + 1
    localparam int CFG_W  = 13;  // config write data
    localparam int IDX_W  = 2;   // config register index
    localparam int GRAD_W = 10;  // |gx|, |gy| up to 1020
    localparam int SQ_W   = 20;  // squared gradient up to 1020^2
    localparam int TSQ_W  = 22;  // squared threshold up to 2047^2

    // register indexes
    localparam logic [IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd2;

    // reset values
    localparam logic [THR_W-1:0]  THR_RESET    = 11'd200;
    localparam logic [FWID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0]  HEIGHT_RESET = 13'd480;

    typedef logic [PIX_W-1:0] t_pix;

    // position info of the window centre for one input word
    typedef struct packed {
        logic has_res;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } t_pos_flags;

endpackage

// ===== sv/sobel_et_ifs.sv =====
// ----------------------------------------------------------------------------
// sobel_et_ifs
// Valid/ready channels of the Sobel edge threshold unit.
// ----------------------------------------------------------------------------
interface sobel_et_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic       flush;
    modport source (output valid, luma, flush, input ready);
    modport sink   (input valid, luma, flush, output ready);
endinterface

interface sobel_et_res_if;
    logic valid;
    logic ready;
    logic edge_res;
    logic last_of_frame;
    modport source (output valid, edge_res, last_of_frame, input ready);
    modport sink   (input valid, edge_res, last_of_frame, output ready);
endinterface

interface sobel_et_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/sobel_edge_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_threshold_unit
// Streaming 3x3 Sobel edge detector with squared-magnitude threshold.
//
//   channel   dir  payload                    accepted when
//   i_pix     in   luma[7:0], flush           valid && ready
//   o_res     out  edge_res, last_of_frame    valid && ready
//   i_cfg     in   index[1:0], data[12:0]     valid && ready (ready tied high)
//
// One pixel word per clock while i_pix.ready is high; four register stages
// from input to result (input/line store read, gradients, squares, compare).
// The result for a pixel leaves with the word width+1 positions later.
// Reset is synchronous; the line store is not cleared, border masking
// keeps unwritten columns out of every result.
// A stalled output fills the stages behind it before i_pix.ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_unit import sobel_et_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sobel_et_pix_if.sink   i_pix,
    sobel_et_res_if.source o_res,
    sobel_et_cfg_if.sink   i_cfg
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);

    // config registers
    logic [THR_W-1:0] r_thr;
    logic [TSQ_W-1:0] r_thr_sq;
    logic [WID_W-1:0] r_eff_w;
    logic [HGT_W-1:0] r_eff_h;

    // position of the next input word
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // input stage
    logic             r_s1_valid;
    t_pix             r_s1_cur;
    logic [COL_W-1:0] r_s1_col;
    t_pos_flags       r_s1_flags;

    logic        pix_acc, s1_adv, cfg_acc, geo_wr;
    logic        win_ready, win_valid, win_last;
    logic [GRAD_W-1:0] win_ax, win_ay;
    logic [15:0] ls_rd_data;
    logic        c0;
    logic [ROW_W-1:0] h_ext, qr;
    t_pos_flags  n_flags;
    t_pix        n_cur;
    logic        mag_ready;
    logic        res_valid, res_edge, res_last;

    function automatic logic [WID_W-1:0] f_eff_width(input logic [FWID_W-1:0] fw);
        if (fw == '0) begin
            return WID_W'(1);
        end else if (int'(fw) > MAX_WIDTH) begin
            return WID_W'(MAX_WIDTH);
        end
        return WID_W'(fw);
    endfunction

    function automatic logic [HGT_W-1:0] f_eff_height(input logic [HGT_W-1:0] fh);
        return (fh == '0) ? HGT_W'(1) : fh;
    endfunction

    // config port
    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign geo_wr      = cfg_acc && ((i_cfg.index == CFG_FRAME_WIDTH) ||
                                     (i_cfg.index == CFG_FRAME_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_eff_w <= f_eff_width(WIDTH_RESET);
            r_eff_h <= f_eff_height(HEIGHT_RESET);
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_EDGE_THRESHOLD: r_thr   <= i_cfg.data[THR_W-1:0];
                CFG_FRAME_WIDTH:    r_eff_w <= f_eff_width(i_cfg.data[FWID_W-1:0]);
                CFG_FRAME_HEIGHT:   r_eff_h <= f_eff_height(i_cfg.data[HGT_W-1:0]);
                default: ;
            endcase
        end
    end

    // squared threshold, registered from r_thr
    always_ff @(posedge i_clk) begin
        r_thr_sq <= TSQ_W'(r_thr) * TSQ_W'(r_thr);
    end

    // input handshake
    assign i_pix.ready = !r_s1_valid || win_ready;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign s1_adv      = r_s1_valid && win_ready;

    // centre position and border flags of the incoming word
    always_comb begin
        c0    = (r_col == '0);
        h_ext = ROW_W'(r_eff_h);
        qr    = r_row - (c0 ? ROW_W'(2) : ROW_W'(1));
        n_flags.has_res  = (c0 ? (r_row >= ROW_W'(2)) : (r_row != '0)) && (qr < h_ext);
        n_flags.top_ok   = (qr != '0);
        n_flags.bot_ok   = ((qr + ROW_W'(1)) < h_ext);
        n_flags.left_ok  = c0 ? (r_eff_w > WID_W'(1)) : (r_col > COL_W'(1));
        n_flags.right_ok = !c0;
        n_flags.last     = c0 && (r_row == (h_ext + ROW_W'(1)));
        n_cur = (i_pix.flush || (r_row >= h_ext)) ? '0 : t_pix'(i_pix.luma);
    end

    // next position
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (geo_wr || n_flags.last) begin
            n_col = '0;
            n_row = '0;
        end else if ((WID_W'(r_col) + WID_W'(1)) >= r_eff_w) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (geo_wr || pix_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // input stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_cur   <= n_cur;
            r_s1_col   <= r_col;
            r_s1_flags <= n_flags;
        end
    end

    // line store: upper in the high byte, middle in the low byte
    sobel_et_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({ls_rd_data[7:0], r_s1_cur}),
        .o_rd_data (ls_rd_data)
    );

    sobel_et_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (s1_adv),
        .i_col_up  (ls_rd_data[15:8]),
        .i_col_mid (ls_rd_data[7:0]),
        .i_col_cur (r_s1_cur),
        .i_flags   (r_s1_flags),
        .i_ready   (mag_ready),
        .o_ready   (win_ready),
        .o_valid   (win_valid),
        .o_ax      (win_ax),
        .o_ay      (win_ay),
        .o_last    (win_last)
    );

    sobel_et_mag_cmp u_mag_cmp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (win_valid),
        .i_ax        (win_ax),
        .i_ay        (win_ay),
        .i_last      (win_last),
        .i_thr_sq    (r_thr_sq),
        .o_ready     (mag_ready),
        .o_valid     (res_valid),
        .o_edge_res  (res_edge),
        .o_last      (res_last),
        .i_out_ready (o_res.ready)
    );

    assign o_res.valid         = res_valid;
    assign o_res.edge_res      = res_edge;
    assign o_res.last_of_frame = res_last;

endmodule

// ===== sv/sobel_et_line_store.sv =====
// ----------------------------------------------------------------------------
// sobel_et_line_store
// Two previous rows packed in one word per column, registered read with
// bypass when the same column is written at the same edge.
// ----------------------------------------------------------------------------
module sobel_et_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [15:0]              i_wr_data,
    output logic [15:0]              o_rd_data
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, new data wins on a same-column collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sobel_et_window.sv =====
// ----------------------------------------------------------------------------
// sobel_et_window
// 3x3 window columns, border masking and both Sobel kernels; registers the
// absolute gradients of each word that yields a result.
// ----------------------------------------------------------------------------
module sobel_et_window import sobel_et_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_pix              i_col_up,
    input  t_pix              i_col_mid,
    input  t_pix              i_col_cur,
    input  t_pos_flags        i_flags,
    input  logic              i_ready,
    output logic              o_ready,
    output logic              o_valid,
    output logic [GRAD_W-1:0] o_ax,
    output logic [GRAD_W-1:0] o_ay,
    output logic              o_last
);

    // last two loaded columns, index 0 top .. 2 bottom
    t_pix r_prev1 [3];
    t_pix r_prev2 [3];

    logic              r_valid;
    logic [GRAD_W-1:0] r_ax;
    logic [GRAD_W-1:0] r_ay;
    logic              r_last;

    t_pix tl, tm, tr, ml, mr, bl, bm, br;
    logic signed [11:0] gx, gy;
    logic signed [11:0] n_ax, n_ay;

    function automatic logic signed [11:0] f_sx(input t_pix v);
        return $signed({4'b0000, v});
    endfunction

    // masked neighbors and kernels
    always_comb begin
        tl = (i_flags.top_ok && i_flags.left_ok)  ? r_prev2[0] : '0;
        tm = i_flags.top_ok                       ? r_prev1[0] : '0;
        tr = (i_flags.top_ok && i_flags.right_ok) ? i_col_up   : '0;
        ml = i_flags.left_ok                      ? r_prev2[1] : '0;
        mr = i_flags.right_ok                     ? i_col_mid  : '0;
        bl = (i_flags.bot_ok && i_flags.left_ok)  ? r_prev2[2] : '0;
        bm = i_flags.bot_ok                       ? r_prev1[2] : '0;
        br = (i_flags.bot_ok && i_flags.right_ok) ? i_col_cur  : '0;
        gx = (f_sx(tr) - f_sx(tl)) + ((f_sx(mr) - f_sx(ml)) <<< 1) + (f_sx(br) - f_sx(bl));
        gy = (f_sx(tl) + (f_sx(tm) <<< 1) + f_sx(tr))
           - (f_sx(bl) + (f_sx(bm) <<< 1) + f_sx(br));
        n_ax = (gx < 0) ? -gx : gx;
        n_ay = (gy < 0) ? -gy : gy;
    end

    // window shift on every word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_prev1[i] <= '0;
                r_prev2[i] <= '0;
            end
        end else if (i_adv) begin
            r_prev2   <= r_prev1;
            r_prev1[0] <= i_col_up;
            r_prev1[1] <= i_col_mid;
            r_prev1[2] <= i_col_cur;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // gradient stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_adv && i_flags.has_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_adv) begin
            r_ax   <= n_ax[GRAD_W-1:0];
            r_ay   <= n_ay[GRAD_W-1:0];
            r_last <= i_flags.last;
        end
    end

    assign o_valid = r_valid;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;
    assign o_last  = r_last;

endmodule

// ===== sv/sobel_et_mag_cmp.sv =====
// ----------------------------------------------------------------------------
// sobel_et_mag_cmp
// Squares the gradients, compares the sum with the squared threshold and
// holds the result word for the output channel.
// ----------------------------------------------------------------------------
module sobel_et_mag_cmp import sobel_et_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [GRAD_W-1:0] i_ax,
    input  logic [GRAD_W-1:0] i_ay,
    input  logic              i_last,
    input  logic [TSQ_W-1:0]  i_thr_sq,
    output logic              o_ready,
    output logic              o_valid,
    output logic              o_edge_res,
    output logic              o_last,
    input  logic              i_out_ready
);

    logic            r_sq_valid;
    logic [SQ_W-1:0] r_sq_x;
    logic [SQ_W-1:0] r_sq_y;
    logic            r_sq_last;

    logic r_out_valid;
    logic r_out_edge;
    logic r_out_last;

    logic            out_ready;
    logic [TSQ_W-1:0] mag2;

    assign out_ready = !r_out_valid || i_out_ready;
    assign o_ready   = !r_sq_valid || out_ready;

    // square stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
        end else if (o_ready) begin
            r_sq_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sq_x    <= SQ_W'(i_ax) * SQ_W'(i_ax);
            r_sq_y    <= SQ_W'(i_ay) * SQ_W'(i_ay);
            r_sq_last <= i_last;
        end
    end

    // sum and compare
    assign mag2 = TSQ_W'(r_sq_x) + TSQ_W'(r_sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_sq_valid) begin
            r_out_edge <= (mag2 > i_thr_sq);
            r_out_last <= r_sq_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_edge_res = r_out_edge;
    assign o_last     = r_out_last;

endmodule

// ===== sv/sobel_et_checker.sv =====
// ----------------------------------------------------------------------------
// sobel_et_checker
// Port-level checks of the Sobel edge threshold unit, bound to the top.
// ----------------------------------------------------------------------------
module sobel_et_port_props (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_pix_ready,
    input logic i_res_valid,
    input logic i_res_ready,
    input logic i_res_edge,
    input logic i_res_last
);

    // no result straight out of reset
    a_no_res_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_res_valid)
        else $error("result valid right after reset");

    // input backpressure only when the whole pipe is full behind a stalled output
    a_ready_low_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix_ready |-> (i_res_valid && !i_res_ready))
        else $error("input stalled while output not blocked");

    // a waiting result stays
    a_res_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its payload
    a_res_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> ($stable(i_res_edge) && $stable(i_res_last)))
        else $error("result payload changed while stalled");

endmodule

bind sobel_edge_threshold_unit sobel_et_port_props u_sobel_et_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_edge  (o_res.edge_res),
    .i_res_last  (o_res.last_of_frame)
);

// ===== tb/sobel_et_checker.sv =====
// ----------------------------------------------------------------------------
// sobel_et_checker
// Watches the pixel, result and register channels of the Sobel edge unit,
// keeps its own line stores, 3x3 window and frame position, works out the
// edge decision for each window centre inside the frame and compares each
// result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sobel_et_checker import sobel_et_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    sobel_et_pix_if i_pix,
    sobel_et_res_if i_res,
    sobel_et_cfg_if i_cfg,
    output int      o_mismatches,
    output int      o_pending,
    output int      o_results,
    output int      o_edges,
    output int      o_frame_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 40;
    localparam int ROW_SAT    = 'h3FFF;

    typedef struct packed {
        logic edge_res;
        logic last_of_frame;
    } t_edge_word;

    // shadow registers
    logic [THR_W-1:0]  thr_reg;
    logic [FWID_W-1:0] width_reg;
    logic [HGT_W-1:0]  height_reg;

    // shadow line stores and window, window is [column][row]
    t_pix upper_row  [MAX_WIDTH];
    t_pix middle_row [MAX_WIDTH];
    t_pix win [3][3];

    int unsigned col_pos;
    int unsigned row_pos;

    t_edge_word pending_edges [$];

    int mismatch_count  = 0;
    int result_count    = 0;
    int edge_count      = 0;
    int frame_end_count = 0;

    // effective geometry after clamping
    function automatic int unsigned frame_cols();
        if (width_reg == '0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned frame_rows();
        return (height_reg == '0) ? 1 : height_reg;
    endfunction

    task automatic reset_predictor();
        thr_reg    = THR_RESET;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        for (int k = 0; k < MAX_WIDTH; k++) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                win[j][k] = '0;
            end
        end
        col_pos = 0;
        row_pos = 0;
        pending_edges.delete();
        mismatch_count  = 0;
        result_count    = 0;
        edge_count      = 0;
        frame_end_count = 0;
    endtask

    // register write, geometry writes restart the frame
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_EDGE_THRESHOLD: begin
                thr_reg = data[THR_W-1:0];
            end
            CFG_FRAME_WIDTH: begin
                width_reg = data[FWID_W-1:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            CFG_FRAME_HEIGHT: begin
                height_reg = data[HGT_W-1:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            default: begin
            end
        endcase
    endtask

    // shift one pixel word into the window and predict the centre decision
    task automatic slide_window(input t_pix luma, input logic flush);
        int unsigned w, h, c, r, idx, qc;
        int qr, gx, gy, mag2, thr2;
        int v [3][3];
        t_pix cur;
        logic top_ok, bot_ok, left_ok, right_ok, ok;
        t_edge_word word;
        w   = frame_cols();
        h   = frame_rows();
        c   = col_pos;
        r   = row_pos;
        idx = c % MAX_WIDTH;
        cur = (flush || r >= h) ? t_pix'(0) : luma;

        for (int k = 0; k < 3; k++) begin
            win[0][k] = win[1][k];
            win[1][k] = win[2][k];
        end
        win[2][0]       = upper_row[idx];
        win[2][1]       = middle_row[idx];
        win[2][2]       = cur;
        upper_row[idx]  = middle_row[idx];
        middle_row[idx] = cur;

        // centre sits width+1 positions back
        if (c == 0) begin
            qc = w - 1;
            qr = int'(r) - 2;
        end else begin
            qc = c - 1;
            qr = int'(r) - 1;
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            if (row_pos < ROW_SAT) row_pos++;
        end else begin
            col_pos = c + 1;
        end

        if (qr < 0 || qr >= int'(h) || qc >= w) return;

        top_ok   = qr > 0;
        bot_ok   = qr + 1 < int'(h);
        left_ok  = qc > 0;
        right_ok = qc + 1 < w;

        // mask neighbors outside the frame
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                ok = 1'b1;
                if (i == 0 && !top_ok) ok = 1'b0;
                if (i == 2 && !bot_ok) ok = 1'b0;
                if (j == 0 && !left_ok) ok = 1'b0;
                if (j == 2 && !right_ok) ok = 1'b0;
                v[i][j] = ok ? int'(win[j][i]) : 0;
            end
        end

        gx   = (v[0][2] - v[0][0]) + 2 * (v[1][2] - v[1][0]) + (v[2][2] - v[2][0]);
        gy   = (v[0][0] + 2 * v[0][1] + v[0][2]) - (v[2][0] + 2 * v[2][1] + v[2][2]);
        mag2 = gx * gx + gy * gy;
        thr2 = int'(thr_reg) * int'(thr_reg);

        word.edge_res      = mag2 > thr2;
        word.last_of_frame = (qr == int'(h) - 1) && (qc == w - 1);
        pending_edges.push_back(word);
        if (word.last_of_frame) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    task automatic flag_mismatch(input string field, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $error("%s mismatch: expected %0b, got %0b", field, want, got);
    endtask

    // compare one result word with the oldest prediction
    task automatic check_result(input logic edge_res, input logic last_flag);
        t_edge_word want;
        result_count++;
        if (edge_res === 1'b1) edge_count++;
        if (last_flag === 1'b1) frame_end_count++;
        if (pending_edges.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $error("result word with no pixel awaiting it: edge_res=%0b last_of_frame=%0b",
                       edge_res, last_flag);
            return;
        end
        want = pending_edges.pop_front();
        if (edge_res !== want.edge_res) flag_mismatch("edge_res", want.edge_res, edge_res);
        if (last_flag !== want.last_of_frame)
            flag_mismatch("last_of_frame", want.last_of_frame, last_flag);
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            if (i_res.valid && i_res.ready) check_result(i_res.edge_res, i_res.last_of_frame);
            if (i_cfg.valid && i_cfg.ready) write_register(i_cfg.index, i_cfg.data);
            if (i_pix.valid && i_pix.ready) slide_window(i_pix.luma, i_pix.flush);
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_edges.size();
        o_results    <= result_count;
        o_edges      <= edge_count;
        o_frame_ends <= frame_end_count;
    end

endmodule

// ===== tb/tb_sobel_edge_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sobel_edge_threshold_unit
// Drives pixel frames and register writes into the Sobel edge unit: a short
// directed pass over border cases, clamped geometry and threshold extremes,
// a backpressure pass, a very tall frame, then random frames with random
// images, flushes and bursty traffic. The checker does the prediction; this
// module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold_unit import sobel_et_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH     = 1024;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS  = 700;

    // index with no register behind it
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        STYLE_NOISE,
        STYLE_CHECKER,
        STYLE_STRIPES,
        STYLE_RAMP,
        STYLE_FLAT
    } t_image_style;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    sobel_et_pix_if pix_if();
    sobel_et_res_if res_if();
    sobel_et_cfg_if cfg_if();

    int mismatches, pending, results_seen, edges_seen, frame_ends;

    int burst_left    = 0;
    int max_gap       = 4;
    int words_sent    = 0;
    int reg_writes    = 0;
    int hold_requests = 0;
    t_reg_write write_queue [$];

    sobel_edge_threshold_unit #(.MAX_WIDTH(MAX_WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    sobel_et_checker #(.MAX_WIDTH(MAX_WIDTH)) u_edge_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results_seen),
        .o_edges      (edges_seen),
        .o_frame_ends (frame_ends)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result ready: random stall modes plus a long hold-off on request
    initial begin : res_ready_gen
        int stall_pct, mode_left, hold_served;
        stall_pct   = 0;
        mode_left   = 0;
        hold_served = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served++;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(200, 20);
                case ($urandom_range(4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            res_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles with no word accepted anywhere
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word accepted for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_pix pick_luma(input t_image_style style, input int col, input int row);
        case (style)
            STYLE_CHECKER: return ((col + row) % 2 == 1) ? 8'hFF : 8'h00;
            STYLE_STRIPES: return (col % 3 == 0) ? 8'hFF : 8'h00;
            STYLE_RAMP:    return t_pix'(col * 9 + row * 4 + $urandom_range(2));
            STYLE_FLAT:    return t_pix'(128 + $urandom_range(3));
            default:       return t_pix'($urandom);
        endcase
    endfunction

    // threshold mostly in the range where random images straddle it
    function automatic logic [CFG_W-1:0] threshold_data();
        int t;
        case ($urandom_range(9))
            0: t = 0;
            1: t = 2047;
            2, 3, 4, 5: t = $urandom_range(80, 1);
            6, 7, 8: t = $urandom_range(400, 80);
            default: t = $urandom_range(1443, 400);
        endcase
        return {2'($urandom), 11'(t)};
    endfunction

    // width 1 may be written as 0, unused upper data bits random
    function automatic logic [CFG_W-1:0] width_data(input int w);
        if (w == 1 && $urandom_range(1) == 1) return {2'($urandom), 11'd0};
        return {2'($urandom), 11'(w)};
    endfunction

    function automatic logic [CFG_W-1:0] height_data(input int h);
        if (h == 1 && $urandom_range(1) == 1) return '0;
        return CFG_W'(h);
    endfunction

    task automatic queue_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        write_queue.push_back({idx, data});
    endtask

    // one pixel word, sender idles between random bursts
    task automatic send_word(input t_pix luma, input logic flush);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(max_gap, 0);
            burst_left = $urandom_range(40, 1);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        pix_if.valid <= 1'b1;
        pix_if.luma  <= luma;
        pix_if.flush <= flush;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        burst_left--;
        words_sent++;
    endtask

    // stop sending and wait for every predicted result plus pipeline settle
    task automatic drain_to_idle();
        pix_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write queued registers back to back once the unit is idle
    task automatic idle_and_write();
        t_reg_write wr;
        drain_to_idle();
        while (write_queue.size() > 0) begin
            wr = write_queue.pop_front();
            cfg_if.valid <= 1'b1;
            cfg_if.index <= wr.idx;
            cfg_if.data  <= wr.data;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            reg_writes++;
        end
        cfg_if.valid <= 1'b0;
    endtask

    // count pixel words of a w x h frame, then width+1 drain words if complete
    task automatic stream_frame(input int w, input int h, input int count,
                                input t_image_style style, input int flush_pct,
                                input bit junk_drain, input int hold_at);
        for (int p = 0; p < count; p++) begin
            if (p == hold_at) hold_requests <= hold_requests + 1;
            send_word(pick_luma(style, p % w, p / w), $urandom_range(99) < flush_pct);
        end
        if (count >= w * h) begin
            for (int p = 0; p <= w; p++) begin
                send_word(t_pix'($urandom), junk_drain ? logic'($urandom_range(1)) : 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        int rand_base, cur_w, cur_h, count, hold_at;
        bit mid_frame, geo_change;

        i_rst_n      <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.luma  <= '0;
        pix_if.flush <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 checkerboard of the extremes at the reset threshold
        queue_reg(CFG_FRAME_WIDTH, 13'd3);
        queue_reg(CFG_FRAME_HEIGHT, 13'd3);
        idle_and_write();
        stream_frame(3, 3, 9, STYLE_CHECKER, 0, 1'b0, -1);

        // width 0 taken as one column, zero threshold
        queue_reg(CFG_EDGE_THRESHOLD, 13'd0);
        queue_reg(CFG_FRAME_WIDTH, 13'd0);
        queue_reg(CFG_FRAME_HEIGHT, 13'd2);
        idle_and_write();
        stream_frame(1, 2, 2, STYLE_CHECKER, 0, 1'b0, -1);

        // height 0 taken as one row, all threshold bits set, live words past the frame
        queue_reg(CFG_EDGE_THRESHOLD, 13'h1FFF);
        queue_reg(CFG_FRAME_WIDTH, 13'd2);
        queue_reg(CFG_FRAME_HEIGHT, 13'd0);
        idle_and_write();
        stream_frame(2, 1, 2, STYLE_NOISE, 0, 1'b1, -1);

        // unused index, flush inside a frame, geometry write mid-frame
        queue_reg(CFG_UNUSED, CFG_W'($urandom));
        queue_reg(CFG_EDGE_THRESHOLD, 13'd60);
        queue_reg(CFG_FRAME_WIDTH, 13'd3);
        queue_reg(CFG_FRAME_HEIGHT, 13'd2);
        idle_and_write();
        send_word(8'hFF, 1'b0);
        send_word(8'h5A, 1'b1);
        send_word(8'h00, 1'b0);
        queue_reg(CFG_FRAME_HEIGHT, 13'd2);
        idle_and_write();
        stream_frame(3, 2, 6, STYLE_NOISE, 30, 1'b0, -1);

        // receiver holds off while words keep coming
        queue_reg(CFG_EDGE_THRESHOLD, 13'd90);
        queue_reg(CFG_FRAME_WIDTH, 13'd5);
        queue_reg(CFG_FRAME_HEIGHT, 13'd24);
        idle_and_write();
        max_gap = 0;
        stream_frame(5, 24, 120, STYLE_NOISE, 0, 1'b0, 7);

        // tallest frame, only its start
        max_gap = 3;
        queue_reg(CFG_EDGE_THRESHOLD, 13'd8);
        queue_reg(CFG_FRAME_WIDTH, 13'd3);
        queue_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        idle_and_write();
        stream_frame(3, 8191, 40, STYLE_RAMP, 0, 1'b0, -1);
        mid_frame = 1'b1;

        // random frames, mostly small, some back to back
        cur_w     = 3;
        cur_h     = 1;
        rand_base = words_sent;
        while (words_sent - rand_base < RANDOM_WORDS) begin
            geo_change = mid_frame || ($urandom_range(9) < 6);
            if (geo_change) begin
                cur_w = ($urandom_range(5) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                cur_h = $urandom_range(10, 1);
                queue_reg(CFG_FRAME_WIDTH, width_data(cur_w));
                queue_reg(CFG_FRAME_HEIGHT, height_data(cur_h));
            end
            if (geo_change ? ($urandom_range(1) == 1) : ($urandom_range(2) == 0))
                queue_reg(CFG_EDGE_THRESHOLD, threshold_data());
            if (write_queue.size() > 0) idle_and_write();

            case ($urandom_range(3))
                0: max_gap = 0;
                1: max_gap = 8;
                default: max_gap = 2;
            endcase

            count     = cur_w * cur_h;
            mid_frame = 1'b0;
            if ($urandom_range(7) == 0) begin
                count     = $urandom_range(count - 1, 0);
                mid_frame = 1'b1;
            end
            hold_at = -1;
            stream_frame(cur_w, cur_h, count, t_image_style'($urandom_range(4)),
                         ($urandom_range(3) == 0) ? 8 : 0, 1'($urandom_range(1)), hold_at);
        end

        drain_to_idle();
        $display("Sent %0d pixel words and %0d register writes; checked %0d results,",
                 words_sent, reg_writes, results_seen);
        $display("%0d edges, %0d frame ends over widths 0 to 40, heights up to 8191,",
                 edges_seen, frame_ends);
        $display("thresholds 0 to 2047, mid-frame restarts and a long output hold-off.");
        if (mismatches == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
